/* rtl/core/pplr_pkg.sv */
// Package for the ping-pong line receiver: sizes, character codes, request type.
`timescale 1ns / 1ps
package pplr_pkg;

  localparam int unsigned LINE_CAPACITY = 64;
  localparam int unsigned IDX_W         = $clog2(LINE_CAPACITY);
  localparam int unsigned ADDR_W        = IDX_W + 1;
  localparam int unsigned BANK_DEPTH    = 1 << ADDR_W;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  typedef enum logic {
    OP_RX_BYTE = 1'b0,
    OP_FETCH   = 1'b1
  } opcode_e;

  // Fetch request snapshot passed from front to back.
  typedef struct packed {
    logic             line_valid;
    logic             bank;
    logic [IDX_W-1:0] len;
    logic             overrun;
    logic             overflow;
  } fetch_req_t;

endpackage

/* rtl/core/pplr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pplr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pplr_front.sv */
// Front end: accepts requests, stores received bytes, tracks banks and flags.
`timescale 1ns / 1ps
module pplr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [pplr_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                       back_busy_i,
  input  logic                       q_full_i,
  input  logic                       q_empty_i,
  output logic                       q_push_o,
  output pplr_pkg::fetch_req_t       q_req_o,
  output logic                       ram_we_o,
  output logic [pplr_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic [pplr_pkg::BYTE_W-1:0] ram_wdata_o
);
  import pplr_pkg::*;

  logic             active_q, active_d;
  logic [IDX_W-1:0] fill_q [2];
  logic [IDX_W-1:0] fill_d [2];
  logic             ready_q, ready_d;
  logic             overrun_q, overrun_d;
  logic             overflow_q, overflow_d;
  logic             is_eol;
  logic             is_fetch;
  logic             accept;
  logic [IDX_W-1:0] idx;

  assign is_fetch = (opcode_e'(opcode_i) == OP_FETCH);
  assign is_eol   = (rx_byte_i == CHAR_LF) || (rx_byte_i == CHAR_CR);
  assign idx      = fill_q[active_q];

  // An end of line would hand the streamed bank back to the writer: hold it.
  always_comb begin
    if (is_fetch) begin
      in_stall_o = q_full_i;
    end else begin
      in_stall_o = is_eol && (back_busy_i || !q_empty_i);
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  assign q_push_o            = accept && is_fetch;
  assign q_req_o.line_valid  = ready_q;
  assign q_req_o.bank        = ~active_q;
  assign q_req_o.len         = fill_q[~active_q];
  assign q_req_o.overrun     = overrun_q;
  assign q_req_o.overflow    = overflow_q;

  assign ram_we_o    = accept && !is_fetch;
  assign ram_waddr_o = {active_q, idx};
  assign ram_wdata_o = is_eol ? '0 : rx_byte_i;

  always_comb begin
    active_d   = active_q;
    fill_d     = fill_q;
    ready_d    = ready_q;
    overrun_d  = overrun_q;
    overflow_d = overflow_q;
    if (accept) begin
      if (is_fetch) begin
        ready_d = 1'b0;
      end else if (is_eol) begin
        active_d = ~active_q;
        fill_d[~active_q] = '0;
        if (ready_q) begin
          overrun_d = 1'b1;
        end else begin
          ready_d = 1'b1;
        end
      end else if (idx == IDX_W'(LINE_CAPACITY - 1)) begin
        fill_d[active_q] = '0;
        overflow_d = 1'b1;
      end else begin
        fill_d[active_q] = idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      fill_q[0]  <= '0;
      fill_q[1]  <= '0;
      ready_q    <= 1'b0;
      overrun_q  <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      fill_q     <= fill_d;
      ready_q    <= ready_d;
      overrun_q  <= overrun_d;
      overflow_q <= overflow_d;
    end
  end

endmodule

/* rtl/core/pplr_queue.sv */
// Short request queue between front and back end.
`timescale 1ns / 1ps
module pplr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pplr_pkg::fetch_req_t push_req_i,
  input  logic                 pop_i,
  output pplr_pkg::fetch_req_t head_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import pplr_pkg::*;

  fetch_req_t        entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/pplr_back.sv */
// Back end: streams a completed line from the bank RAM into the output register.
`timescale 1ns / 1ps
module pplr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pplr_pkg::fetch_req_t        head_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  output logic                        busy_o,
  output logic                        ram_re_o,
  output logic [pplr_pkg::ADDR_W-1:0] ram_raddr_o,
  input  logic [pplr_pkg::BYTE_W-1:0] ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        line_valid_o,
  output logic [pplr_pkg::BYTE_W-1:0] line_byte_o,
  output logic [pplr_pkg::LEN_W-1:0]  line_length_o,
  output logic                        last_byte_o,
  output logic                        overrun_flag_o,
  output logic                        overflow_flag_o
);
  import pplr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DATA
  } state_e;

  state_e           state_q;
  fetch_req_t       cur_q;
  logic [IDX_W-1:0] cnt_q;
  logic             out_free;
  logic             at_end;
  logic             out_load;

  assign out_free = !out_valid_o || !out_stall_i;
  assign at_end   = (cnt_q == cur_q.len);
  assign busy_o   = (state_q != ST_IDLE);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i && (head_i.line_valid || out_free);
  assign out_load = ((state_q == ST_IDLE) && q_pop_o && !head_i.line_valid) ||
                    ((state_q == ST_DATA) && out_free);

  always_comb begin
    ram_re_o    = 1'b0;
    ram_raddr_o = {head_i.bank, {IDX_W{1'b0}}};
    unique case (state_q)
      ST_IDLE: begin
        ram_re_o = q_pop_o && head_i.line_valid;
      end
      ST_DATA: begin
        ram_re_o    = out_free && !at_end;
        ram_raddr_o = {cur_q.bank, cnt_q + 1'b1};
      end
      default: begin
        ram_re_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cur_q           <= '0;
      cnt_q           <= '0;
      out_valid_o     <= 1'b0;
      line_valid_o    <= 1'b0;
      line_byte_o     <= '0;
      line_length_o   <= '0;
      last_byte_o     <= 1'b0;
      overrun_flag_o  <= 1'b0;
      overflow_flag_o <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            cur_q <= head_i;
            cnt_q <= '0;
            if (head_i.line_valid) begin
              state_q <= ST_DATA;
            end else begin
              line_valid_o    <= 1'b0;
              line_byte_o     <= '0;
              line_length_o   <= '0;
              last_byte_o     <= 1'b1;
              overrun_flag_o  <= head_i.overrun;
              overflow_flag_o <= head_i.overflow;
            end
          end
        end
        ST_DATA: begin
          if (out_free) begin
            line_valid_o    <= 1'b1;
            line_byte_o     <= ram_rdata_i;
            line_length_o   <= LEN_W'(cur_q.len);
            last_byte_o     <= at_end;
            overrun_flag_o  <= cur_q.overrun;
            overflow_flag_o <= cur_q.overflow;
            if (at_end) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ping_pong_line_receiver_top.sv */
// Ping-pong line receiver: received bytes in, completed lines streamed out.
// Received byte: one per cycle; a line end waits while a fetch is queued or being streamed.
// Fetch: empty result from the queue head, line bytes from RAM, one a cycle when not stalled.
// Streaming rate is set by the single registered read port of the bank RAM.
// Reset (async, active low) clears banks' indexes, flags, queue and output; RAM is not cleared.
`timescale 1ns / 1ps
module ping_pong_line_receiver_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [pplr_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        line_valid_o,
  output logic [pplr_pkg::BYTE_W-1:0] line_byte_o,
  output logic [pplr_pkg::LEN_W-1:0]  line_length_o,
  output logic                        last_byte_o,
  output logic                        overrun_flag_o,
  output logic                        overflow_flag_o
);
  import pplr_pkg::*;

  fetch_req_t        push_req;
  fetch_req_t        head_req;
  logic              q_push, q_pop, q_full, q_empty;
  logic              back_busy;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  pplr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .back_busy_i (back_busy),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .q_push_o    (q_push),
    .q_req_o     (push_req),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  pplr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_req_i (push_req),
    .pop_i      (q_pop),
    .head_o     (head_req),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  pplr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pplr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_req),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .busy_o          (back_busy),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_valid_o    (line_valid_o),
    .line_byte_o     (line_byte_o),
    .line_length_o   (line_length_o),
    .last_byte_o     (last_byte_o),
    .overrun_flag_o  (overrun_flag_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule

/* rtl/core/pplr_checker.sv */
// Port-level checks for the ping-pong line receiver, bound to the top level.
`timescale 1ns / 1ps
module pplr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        line_valid_o,
  input logic [pplr_pkg::BYTE_W-1:0] line_byte_o,
  input logic [pplr_pkg::LEN_W-1:0]  line_length_o,
  input logic                        last_byte_o,
  input logic                        overrun_flag_o,
  input logic                        overflow_flag_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_byte_o) && $stable(last_byte_o))
    else $error("stalled result changed");

  a_empty_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_valid_o |-> last_byte_o && line_byte_o == '0 && line_length_o == '0)
    else $error("empty fetch result malformed");

  a_overrun_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && overrun_flag_o |=> !out_valid_o || overrun_flag_o)
    else $error("overrun flag dropped");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && overflow_flag_o |=> !out_valid_o || overflow_flag_o)
    else $error("overflow flag dropped");

endmodule

bind ping_pong_line_receiver_top pplr_checker u_pplr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .line_valid_o    (line_valid_o),
  .line_byte_o     (line_byte_o),
  .line_length_o   (line_length_o),
  .last_byte_o     (last_byte_o),
  .overrun_flag_o  (overrun_flag_o),
  .overflow_flag_o (overflow_flag_o)
);

/* tb/testbench.sv */
// Self-checking testbench for the ping-pong line receiver: random lines, fetches and stalls.
`timescale 1ns / 1ps
module testbench;
  import pplr_pkg::*;

  localparam int unsigned REQUEST_TARGET = 270;
  localparam int unsigned RUN_LIMIT      = 400000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic              last;
    logic              overrun;
    logic              overflow;
  } line_result_t;

  class line_scoreboard;
    logic [BYTE_W-1:0] bank_mem [2][LINE_CAPACITY];
    bit                active;
    logic [IDX_W-1:0]  fill_idx [2];
    bit                line_ready;
    bit                overrun_seen;
    bit                overflow_seen;
    line_result_t      expected_q [$];
    int unsigned       mismatches;

    function new();
      active        = 1'b0;
      fill_idx[0]   = '0;
      fill_idx[1]   = '0;
      line_ready    = 1'b0;
      overrun_seen  = 1'b0;
      overflow_seen = 1'b0;
      mismatches    = 0;
    endfunction

    function void note_request(opcode_e op, logic [BYTE_W-1:0] ch);
      line_result_t     r;
      logic [IDX_W:0]   nxt;
      logic [IDX_W-1:0] len;
      bit               rd;
      if (op == OP_RX_BYTE) begin
        if (ch == CHAR_LF || ch == CHAR_CR) begin
          bank_mem[active][fill_idx[active]] = '0;
          active = ~active;
          if (line_ready) overrun_seen = 1'b1;
          else line_ready = 1'b1;
          fill_idx[active] = '0;
        end else begin
          bank_mem[active][fill_idx[active]] = ch;
          nxt = {1'b0, fill_idx[active]} + 1'b1;
          if (nxt == LINE_CAPACITY) begin
            overflow_seen = 1'b1;
            nxt           = '0;
          end
          fill_idx[active] = nxt[IDX_W-1:0];
        end
        return;
      end
      r.overrun  = overrun_seen;
      r.overflow = overflow_seen;
      if (!line_ready) begin
        r.valid  = 1'b0;
        r.data   = '0;
        r.length = '0;
        r.last   = 1'b1;
        expected_q.push_back(r);
        return;
      end
      rd  = ~active;
      len = fill_idx[rd];
      for (int i = 0; i <= len; i++) begin
        r.valid  = 1'b1;
        r.data   = bank_mem[rd][i];
        r.length = len;
        r.last   = (i == len);
        expected_q.push_back(r);
      end
      line_ready = 1'b0;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(line_result_t act);
      line_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("line result with no request pending");
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("line_valid", exp_r.valid, act.valid);
      compare_field("line_byte", exp_r.data, act.data);
      compare_field("line_length", exp_r.length, act.length);
      compare_field("last_byte", exp_r.last, act.last);
      compare_field("overrun_flag", exp_r.overrun, act.overrun);
      compare_field("overflow_flag", exp_r.overflow, act.overflow);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              opcode_i;
  logic [BYTE_W-1:0] rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              line_valid_o;
  logic [BYTE_W-1:0] line_byte_o;
  logic [LEN_W-1:0]  line_length_o;
  logic              last_byte_o;
  logic              overrun_flag_o;
  logic              overflow_flag_o;

  line_scoreboard line_sb = new();
  int unsigned    requests_sent = 0;
  int unsigned    send_idle_pct = 13;
  int unsigned    recv_idle_pct = 74;
  int unsigned    cycle_count   = 0;

  ping_pong_line_receiver_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_valid_o   (line_valid_o),
    .line_byte_o    (line_byte_o),
    .line_length_o  (line_length_o),
    .last_byte_o    (last_byte_o),
    .overrun_flag_o (overrun_flag_o),
    .overflow_flag_o(overflow_flag_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    line_result_t act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act.valid    = line_valid_o;
      act.data     = line_byte_o;
      act.length   = line_length_o;
      act.last     = last_byte_o;
      act.overrun  = overrun_flag_o;
      act.overflow = overflow_flag_o;
      line_sb.check_result(act);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("ping_pong_line_receiver_top: mismatch");
      $finish;
    end
  end

  task automatic send_request(opcode_e op, logic [BYTE_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    rx_byte_i  <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    line_sb.note_request(op, ch);
    requests_sent++;
    if (requests_sent == REQUEST_TARGET / 3) begin
      send_idle_pct = 74;
      recv_idle_pct = 13;
    end else if (requests_sent == 2 * REQUEST_TARGET / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic send_line(int unsigned len, logic [BYTE_W-1:0] term);
    logic [BYTE_W-1:0] ch;
    repeat (len) begin
      do ch = 8'($urandom_range(255)); while (ch == CHAR_LF || ch == CHAR_CR);
      send_request(OP_RX_BYTE, ch);
    end
    send_request(OP_RX_BYTE, term);
  endtask

  initial begin
    int unsigned len;
    int unsigned fetches;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OP_RX_BYTE;
    rx_byte_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fetch before any line, line with zero and all-ones bytes, empty line, overrun
    send_request(OP_FETCH, 8'hFF);
    send_request(OP_RX_BYTE, 8'h00);
    send_request(OP_RX_BYTE, 8'hFF);
    send_request(OP_RX_BYTE, 8'h41);
    send_request(OP_RX_BYTE, CHAR_LF);
    send_request(OP_FETCH, 8'h00);
    send_request(OP_RX_BYTE, CHAR_CR);
    send_request(OP_FETCH, 8'h55);
    send_request(OP_RX_BYTE, 8'h78);
    send_request(OP_RX_BYTE, CHAR_LF);
    send_request(OP_RX_BYTE, 8'h79);
    send_request(OP_RX_BYTE, CHAR_CR);
    send_request(OP_FETCH, 8'hAA);
    send_request(OP_FETCH, 8'h0A);

    while (requests_sent < REQUEST_TARGET) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(2))
            0: len = LINE_CAPACITY - 1;
            1: len = LINE_CAPACITY;
            default: len = $urandom_range(90, 50);
          endcase
        end else begin
          len = $urandom_range(12);
        end
        send_line(len, $urandom_range(1) ? CHAR_LF : CHAR_CR);
        fetches = ($urandom_range(3) == 0) ? 0 : (($urandom_range(4) == 0) ? 2 : 1);
        repeat (fetches) send_request(OP_FETCH, 8'($urandom_range(255)));
      end else begin
        send_request(opcode_e'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
    in_valid_i <= 1'b0;

    while (line_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (line_sb.mismatches == 0) begin
      $display("ping_pong_line_receiver_top: match");
    end else begin
      $display("ping_pong_line_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
